// File: src/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CIW   = AW + 2;
    localparam int OCC_W = 6;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [7:0]  entry_key;
        logic [15:0] entry_tag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_key;
        logic [15:0]      out_tag;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_FINAL,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DONE
    } t_state;

endpackage

// File: src/max_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// A refused item or an insert into an empty heap goes from idle to the done state, then to the output register.
// An insert otherwise moves each smaller parent down as the hole climbs, then writes the entry;
// a remove reads the root and the last entry, then compares the children at each level descended.
// Throughput: one item at a time; the next item is accepted once the result is loaded.
// Each level costs a registered heap memory read and compare, up to two of each (both children) on a remove.
// Reset clears the entry count and the handshake state; heap memory is not cleared.

module max_heap_priority_queue_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mhpq_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mhpq_pkg::t_out_item   o_out_item
);
    import mhpq_pkg::*;

    t_entry          r_mem [DEPTH];
    t_entry          r_rd_data;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_hole, n_hole;
    t_entry          r_cur, n_cur;
    t_entry          r_best, n_best;
    logic            r_best_child, n_best_child;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    logic [7:0]      r_res_key, n_res_key;
    logic [15:0]     r_res_tag, n_res_tag;
    t_status         r_res_status, n_res_status;
    t_out_item       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic            do_resolve;
    t_entry          sel_e;
    logic            sel_child;
    logic [AW-1:0]   sel_idx;
    logic            take;
    logic [AW-1:0]   up_parent;
    logic [AW-1:0]   up_grand;
    logic [AW-1:0]   ins_hole;
    logic [CIW-1:0]  dn_left;
    logic [CIW-1:0]  dn_right;
    logic [CIW-1:0]  next_left;
    logic [CIW-1:0]  count_x;

    // heap storage, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole       <= n_hole;
        r_cur        <= n_cur;
        r_best       <= n_best;
        r_best_child <= n_best_child;
        r_best_idx   <= n_best_idx;
        r_res_key    <= n_res_key;
        r_res_tag    <= n_res_tag;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    assign ins_hole  = AW'(r_count);
    assign up_parent = (r_hole - AW'(1)) >> 1;
    assign up_grand  = (up_parent - AW'(1)) >> 1;
    assign dn_left   = {1'b0, r_hole, 1'b1};
    assign dn_right  = dn_left + CIW'(1);
    assign count_x   = CIW'(r_count);
    assign next_left = {1'b0, sel_idx, 1'b1};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_hole       = r_hole;
        n_cur        = r_cur;
        n_best       = r_best;
        n_best_child = r_best_child;
        n_best_idx   = r_best_idx;
        n_res_key    = r_res_key;
        n_res_tag    = r_res_tag;
        n_res_status = r_res_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        mem_we       = 1'b0;
        wr_addr      = r_hole;
        wr_data      = r_cur;
        rd_en        = 1'b0;
        rd_addr      = '0;
        do_resolve   = 1'b0;
        take         = 1'b0;
        sel_e        = r_cur;
        sel_child    = 1'b0;
        sel_idx      = r_hole;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_key    = '0;
                    n_res_tag    = '0;
                    n_res_status = ST_DONE;
                    if (i_in_item.mode == MODE_INSERT) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_cur   = '{key: i_in_item.entry_key, tag: i_in_item.entry_tag};
                            n_hole  = ins_hole;
                            if (r_count == '0) begin
                                mem_we  = 1'b1;
                                wr_addr = '0;
                                wr_data = n_cur;
                                n_state = S_DONE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = (ins_hole - AW'(1)) >> 1;
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            n_count = r_count - CW'(1);
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_DN_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                // hole climbs while the parent key is smaller and the parent moves down into it; else the entry settles
                if (r_rd_data.key < r_cur.key) begin
                    mem_we  = 1'b1;
                    wr_data = r_rd_data;
                    n_hole  = up_parent;
                    if (up_parent == '0) begin
                        n_state = S_FINAL;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = up_grand;
                    end
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_FINAL: begin
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DN_ROOT: begin
                n_res_key = r_rd_data.key;
                n_res_tag = r_rd_data.tag;
                rd_en     = 1'b1;
                rd_addr   = AW'(r_count);
                n_state   = S_DN_LAST;
            end
            S_DN_LAST: begin
                n_cur  = r_rd_data;
                n_hole = '0;
                if (CIW'(1) < count_x) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(1);
                    n_state = S_DN_LEFT;
                end else begin
                    mem_we  = 1'b1;
                    wr_addr = '0;
                    wr_data = r_rd_data;
                    n_state = S_DONE;
                end
            end
            S_DN_LEFT: begin
                take      = r_rd_data.key > r_cur.key;
                sel_e     = take ? r_rd_data : r_cur;
                sel_child = take;
                sel_idx   = dn_left[AW-1:0];
                if (dn_right < count_x) begin
                    n_best       = sel_e;
                    n_best_child = sel_child;
                    n_best_idx   = sel_idx;
                    rd_en        = 1'b1;
                    rd_addr      = dn_right[AW-1:0];
                    n_state      = S_DN_RIGHT;
                end else begin
                    do_resolve = 1'b1;
                end
            end
            S_DN_RIGHT: begin
                take       = r_rd_data.key > r_best.key;
                sel_e      = take ? r_rd_data : r_best;
                sel_child  = take || r_best_child;
                sel_idx    = take ? dn_right[AW-1:0] : r_best_idx;
                do_resolve = 1'b1;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = '{out_key:   r_res_key,
                              out_tag:   r_res_tag,
                              status:    r_res_status,
                              occupancy: OCC_W'(r_count)};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // larger child moves up into the hole, or the moving entry settles here
        if (do_resolve) begin
            mem_we = 1'b1;
            if (sel_child) begin
                wr_data = sel_e;
                n_hole  = sel_idx;
                if (next_left < count_x) begin
                    rd_en   = 1'b1;
                    rd_addr = next_left[AW-1:0];
                    n_state = S_DN_LEFT;
                end else begin
                    n_state = S_FINAL;
                end
            end else begin
                n_state = S_DONE;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.mode == MODE_INSERT
            && r_count < CW'(DEPTH))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the heap");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> r_state == S_DONE)
        else $error("result overwritten while output stalled");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_FULL)
        |-> o_out_item.occupancy == OCC_W'(DEPTH))
        else $error("full status with heap not full");

endmodule

// File: tb/tb_max_heap_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_top;
    import mhpq_pkg::*;

    typedef struct {
        t_in_item  item;
        logic      pinned;
        t_out_item result;
    } t_row;

    localparam int SCRIPT_LEN   = 25;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_PCT     = 37;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // predictor state
    t_entry    heap_model [DEPTH];
    int        entry_total = 0;
    t_out_item results_due [$];
    int        mismatch_count = 0;
    bit        quiet = 1'b0;
    t_row      script [SCRIPT_LEN];

    max_heap_priority_queue_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_out_item heap_apply(input t_in_item it);
        t_out_item res;
        t_entry    tmp;
        int        pos;
        int        up;
        int        best;
        int        lc;
        int        rc;
        res = '0;
        res.status = ST_DONE;
        if (it.mode == MODE_INSERT) begin
            if (entry_total >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                heap_model[entry_total] = '{key: it.entry_key, tag: it.entry_tag};
                pos = entry_total;
                entry_total++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_model[up].key < heap_model[pos].key) begin
                        tmp = heap_model[up];
                        heap_model[up] = heap_model[pos];
                        heap_model[pos] = tmp;
                        pos = up;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (entry_total == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.out_key = heap_model[0].key;
                res.out_tag = heap_model[0].tag;
                entry_total--;
                heap_model[0] = heap_model[entry_total];
                pos = 0;
                while (pos < entry_total) begin
                    best = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < entry_total && heap_model[lc].key > heap_model[best].key)
                        best = lc;
                    if (rc < entry_total && heap_model[rc].key > heap_model[best].key)
                        best = rc;
                    if (best == pos)
                        break;
                    tmp = heap_model[pos];
                    heap_model[pos] = heap_model[best];
                    heap_model[best] = tmp;
                    pos = best;
                end
            end
        end
        res.occupancy = OCC_W'(entry_total);
        return res;
    endfunction

    // offer one item, hold it until taken, then maybe go idle for a while
    task automatic push_item(input t_in_item it, input logic pinned, input t_out_item pinned_res);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        predicted = heap_apply(it);
        results_due.push_back(pinned ? pinned_res : predicted);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result key=%h tag=%h status=%0d occ=%0d",
                                 o_out_item.out_key, o_out_item.out_tag,
                                 o_out_item.status, o_out_item.occupancy);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_item.out_key !== want.out_key ||
                        o_out_item.out_tag !== want.out_tag ||
                        o_out_item.status !== want.status ||
                        o_out_item.occupancy !== want.occupancy) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp key=%h tag=%h status=%0d occ=%0d,",
                                      " got key=%h tag=%h status=%0d occ=%0d"},
                                     want.out_key, want.out_tag, want.status,
                                     want.occupancy,
                                     o_out_item.out_key, o_out_item.out_tag,
                                     o_out_item.status, o_out_item.occupancy);
                    end
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        t_in_item it;
        int       sent;
        int       burst;
        int       n;
        int       key_style;
        int       insert_pct;
        bit       paused;

        sent = 0;
        paused = 1'b0;

        script = '{
            // remove from empty, key and tag ignored
            '{'{MODE_REMOVE, 8'hFF, 16'hFFFF}, 1'b1, '{8'h00, 16'h0000, ST_EMPTY, 6'd0}},
            '{'{MODE_INSERT, 8'h00, 16'h0000}, 1'b1, '{8'h00, 16'h0000, ST_DONE, 6'd1}},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b1, '{8'h00, 16'h0000, ST_DONE, 6'd0}},
            '{'{MODE_INSERT, 8'hFF, 16'hFFFF}, 1'b1, '{8'h00, 16'h0000, ST_DONE, 6'd1}},
            '{'{MODE_INSERT, 8'h00, 16'h0001}, 1'b1, '{8'h00, 16'h0000, ST_DONE, 6'd2}},
            '{'{MODE_REMOVE, 8'h12, 16'h3456}, 1'b1, '{8'hFF, 16'hFFFF, ST_DONE, 6'd1}},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b1, '{8'h00, 16'h0001, ST_DONE, 6'd0}},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b1, '{8'h00, 16'h0000, ST_EMPTY, 6'd0}},
            // equal keys: order decided by the moves alone
            '{'{MODE_INSERT, 8'h80, 16'h1111}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h80, 16'h2222}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h80, 16'h3333}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h7F, 16'h4444}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h81, 16'h5555}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            // rising keys climb to the root
            '{'{MODE_INSERT, 8'h01, 16'hA5A5}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h02, 16'h5A5A}, 1'b0, '0},
            '{'{MODE_INSERT, 8'h03, 16'h0F0F}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0},
            '{'{MODE_REMOVE, 8'h00, 16'h0000}, 1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++)
            push_item(script[r].item, script[r].pinned, script[r].result);

        wait_drained();

        // bursts of fills, drains and mixes so the full and empty edges are hit often
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(0, 3);
            key_style = $urandom_range(0, 3);
            case (burst)
                0: begin
                    n = $urandom_range(20, 40);
                    insert_pct = 100;
                end
                1: begin
                    n = $urandom_range(20, 40);
                    insert_pct = 0;
                end
                2: begin
                    n = $urandom_range(10, 30);
                    insert_pct = 60;
                end
                default: begin
                    n = $urandom_range(10, 30);
                    insert_pct = 40;
                end
            endcase
            if (!paused && sent >= 500) begin
                paused = 1'b1;
                wait_drained();
            end
            for (int k = 0; k < n; k++) begin
                it.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                case (key_style)
                    0: it.entry_key = 8'($urandom_range(0, 255));
                    1: it.entry_key = 8'($urandom_range(8'h40, 8'h43));
                    2: it.entry_key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: it.entry_key = $urandom_range(0, 1) ?
                                            8'($urandom_range(250, 255)) :
                                            8'($urandom_range(0, 255));
                endcase
                it.entry_tag = 16'($urandom_range(0, 65535));
                quiet = (sent >= 300 && sent < 420);
                push_item(it, 1'b0, '0);
                sent++;
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
